### rtl/tbs_pkg.sv
// Shared types, widths and helpers for the temperature band statistics block.
package tbs_pkg;

  localparam int TALLY_W   = 9;
  localparam int VAL_W     = 15;
  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 23;
  localparam int INDEX_W   = 8;
  localparam int CFG_W     = 15;
  localparam int CFG_ADDR_W = 2;
  localparam int NUM_BANDS = 4;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int OUT_DATA_W = 128;

  localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [VAL_W-1:0]   VAL_MAX   = {VAL_W{1'b1}};

  localparam logic [VAL_W-1:0] NORMAL_LIMIT_RST   = 15'd7424;
  localparam logic [VAL_W-1:0] WARNING_LIMIT_RST  = 15'd11264;
  localparam logic [VAL_W-1:0] CRITICAL_LIMIT_RST = 15'd15104;
  localparam logic [VAL_W-1:0] ALERT_LEVEL_RST    = 15'd11520;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_NORMAL_LIMIT   = 2'd0,
    REG_WARNING_LIMIT  = 2'd1,
    REG_CRITICAL_LIMIT = 2'd2,
    REG_ALERT_LEVEL    = 2'd3
  } cfg_reg_t;

  // Band indexes
  typedef enum logic [1:0] {
    BAND_NORMAL   = 2'd0,
    BAND_WARNING  = 2'd1,
    BAND_CRITICAL = 2'd2,
    BAND_SHUTDOWN = 2'd3
  } band_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;       // accepted sample transaction
    logic div_start;  // launch the average division
    logic emit;       // load the summary register and clear the set
  } tbs_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } tbs_status_t;

  // One summary result
  typedef struct packed {
    logic [VAL_W-1:0]   alert_value;
    logic [INDEX_W-1:0] alert_index;
    logic               alert_found;
    logic [TALLY_W-1:0] valid_count;
    logic [VAL_W-1:0]   average_value;
    logic [VAL_W-1:0]   max_value;
    logic [VAL_W-1:0]   min_value;
    logic [TALLY_W-1:0] shutdown_count;
    logic [TALLY_W-1:0] critical_count;
    logic [TALLY_W-1:0] warning_count;
    logic [TALLY_W-1:0] normal_count;
    logic [TALLY_W-1:0] skipped_count;
  } summary_t;

  localparam int SUMMARY_W = $bits(summary_t);

  // Saturating tally increment
  function automatic logic [TALLY_W-1:0] sat_inc(input logic [TALLY_W-1:0] v);
    logic [TALLY_W-1:0] r;
    r = (v == TALLY_MAX) ? v : v + 1'b1;
    return r;
  endfunction

endpackage

### rtl/temperature_band_statistics.sv
// Top level of the temperature band statistics block.
//
// Samples arrive on the s_ channel: s_tdata carries a signed Q8.8 reading,
// s_tlast marks the final sample of a set. A negative reading is counted as
// skipped. One sample is taken per cycle while the block is collecting.
// After the sample marked last, the block computes the set average with a
// bit-serial divider (one quotient bit per cycle over the 23-bit sum) and
// holds s_tready low until the summary is loaded into the output register;
// the summary then appears on m_, and the collection of the next set
// resumes in the same cycle. The summary stays in an output register until
// the receiver takes it, so the next set can be collected meanwhile; a
// further summary waits in the emit step while the receiver stalls.
// Samples beyond MAX_SAMPLES in one set are dropped. The cfg_ port writes
// the three band limits and the alert level at indexes 0 to 3; write only
// while idle. Reset restores the default limits, clears every statistic and
// empties the output register.
module temperature_band_statistics
  import tbs_pkg::*;
#(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [8:0] skipped_count, [17:9] normal_count, [26:18] warning_count,
  // [35:27] critical_count, [44:36] shutdown_count, [59:45] min_value,
  // [74:60] max_value, [89:75] average_value, [98:90] valid_count,
  // [99] alert_found, [107:100] alert_index, [122:108] alert_value
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data
);

  tbs_cmd_t    cmd;
  tbs_status_t status;
  summary_t    summary;

  tbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tbs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .sample   (s_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .summary  (summary)
  );

  // Pack the summary, last declared field (skipped_count) in the lowest bits
  assign m_tdata = {{(OUT_DATA_W - SUMMARY_W){1'b0}}, summary};

endmodule

### rtl/tbs_div.sv
// Restoring divider, one quotient bit per cycle, for the set average.
module tbs_div
  import tbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  input  logic [TALLY_W-1:0] divisor,
  output logic               done,
  output logic [SUM_W-1:0]   quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TALLY_W-1:0]   rem;
  logic [SUM_W-1:0]     quo;
  logic [TALLY_W-1:0]   dvs;
  logic [TALLY_W:0]     shifted;
  logic [TALLY_W+1:0]   diff;
  logic                 ge;

  // Trial subtraction of the divisor from the shifted remainder
  always_comb begin
    shifted = {rem, quo[SUM_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs};
    ge      = ~diff[TALLY_W+1];
  end

  // Iterate over the dividend bits, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[TALLY_W-1:0] : shifted[TALLY_W-1:0];
        quo <= {quo[SUM_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

  // Completion never overlaps a running division
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

### rtl/tbs_datapath.sv
// Datapath: limit registers, running statistics, divider and summary register.
module tbs_datapath
  import tbs_pkg::*;
#(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tbs_cmd_t              cmd,
  output tbs_status_t           status,
  input  logic [SAMPLE_W-1:0]   sample,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]      cfg_data,
  output summary_t              summary
);

  localparam int POS_W = $clog2(MAX_SAMPLES + 1);

  logic [VAL_W-1:0]   normal_limit;
  logic [VAL_W-1:0]   warning_limit;
  logic [VAL_W-1:0]   critical_limit;
  logic [VAL_W-1:0]   alert_level;

  logic [TALLY_W-1:0] skipped_tally;
  logic [TALLY_W-1:0] band_tallies [NUM_BANDS];
  logic [VAL_W-1:0]   running_min;
  logic [VAL_W-1:0]   running_max;
  logic [SUM_W-1:0]   running_sum;
  logic [TALLY_W-1:0] valid_tally;
  logic [POS_W-1:0]   position;
  logic               alert_seen;
  logic [INDEX_W-1:0] alert_position;
  logic [VAL_W-1:0]   alert_sample;

  logic               pos_full;
  logic [VAL_W-1:0]   v;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_next;
  logic [VAL_W-1:0]   min_next;
  logic [VAL_W-1:0]   max_next;
  band_t              band;
  logic [POS_W+INDEX_W-1:0] pos_ext;
  logic [SUM_W-1:0]   quotient;
  logic [VAL_W-1:0]   average;

  // Classify and combine the incoming sample with the running values
  always_comb begin
    pos_full = (position >= POS_W'(MAX_SAMPLES));
    v        = sample[VAL_W-1:0];
    sum_wide = {1'b0, running_sum} + {{(SUM_W + 1 - VAL_W){1'b0}}, v};
    sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    min_next = ((valid_tally == '0) || (v < running_min)) ? v : running_min;
    max_next = ((valid_tally == '0) || (v > running_max)) ? v : running_max;
    if (v <= normal_limit) begin
      band = BAND_NORMAL;
    end else if (v <= warning_limit) begin
      band = BAND_WARNING;
    end else if (v <= critical_limit) begin
      band = BAND_CRITICAL;
    end else begin
      band = BAND_SHUTDOWN;
    end
    pos_ext  = {{INDEX_W{1'b0}}, position};
  end

  // Truncated average, zero for an empty set, saturated to the value range
  always_comb begin
    if (valid_tally == '0) begin
      average = '0;
    end else if (|quotient[SUM_W-1:VAL_W]) begin
      average = VAL_MAX;
    end else begin
      average = quotient[VAL_W-1:0];
    end
  end

  tbs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (running_sum),
    .divisor  (valid_tally),
    .done     (status.div_done),
    .quotient (quotient)
  );

  // Limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      normal_limit   <= NORMAL_LIMIT_RST;
      warning_limit  <= WARNING_LIMIT_RST;
      critical_limit <= CRITICAL_LIMIT_RST;
      alert_level    <= ALERT_LEVEL_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_NORMAL_LIMIT:   normal_limit   <= cfg_data;
        REG_WARNING_LIMIT:  warning_limit  <= cfg_data;
        REG_CRITICAL_LIMIT: critical_limit <= cfg_data;
        REG_ALERT_LEVEL:    alert_level    <= cfg_data;
        default:            normal_limit   <= normal_limit;
      endcase
    end
  end

  // Running statistics: update on a sample, clear on reset and when the summary is loaded
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      skipped_tally  <= '0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        band_tallies[i] <= '0;
      end
      running_min    <= '0;
      running_max    <= '0;
      running_sum    <= '0;
      valid_tally    <= '0;
      position       <= '0;
      alert_seen     <= 1'b0;
      alert_position <= '0;
      alert_sample   <= '0;
    end else if (cmd.take && !pos_full) begin
      position <= position + 1'b1;
      if (sample[SAMPLE_W-1]) begin
        skipped_tally <= sat_inc(skipped_tally);
      end else begin
        if (!alert_seen && (v >= alert_level)) begin
          alert_seen     <= 1'b1;
          alert_position <= pos_ext[INDEX_W-1:0];
          alert_sample   <= v;
        end
        running_min        <= min_next;
        running_max        <= max_next;
        running_sum        <= sum_next;
        valid_tally        <= sat_inc(valid_tally);
        band_tallies[band] <= sat_inc(band_tallies[band]);
      end
    end
  end

  // Summary register, loaded once the average is known
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      summary.skipped_count  <= skipped_tally;
      summary.normal_count   <= band_tallies[BAND_NORMAL];
      summary.warning_count  <= band_tallies[BAND_WARNING];
      summary.critical_count <= band_tallies[BAND_CRITICAL];
      summary.shutdown_count <= band_tallies[BAND_SHUTDOWN];
      summary.min_value      <= running_min;
      summary.max_value      <= running_max;
      summary.average_value  <= average;
      summary.valid_count    <= valid_tally;
      summary.alert_found    <= alert_seen;
      summary.alert_index    <= alert_position;
      summary.alert_value    <= alert_sample;
    end
  end

  // The running extremes stay ordered
  assert property (@(posedge clk) disable iff (rst) running_min <= running_max)
    else $error("running minimum above running maximum");

  // No band holds more samples than were counted valid
  assert property (@(posedge clk) disable iff (rst)
      (band_tallies[BAND_NORMAL] <= valid_tally) &&
      (band_tallies[BAND_WARNING] <= valid_tally) &&
      (band_tallies[BAND_CRITICAL] <= valid_tally) &&
      (band_tallies[BAND_SHUTDOWN] <= valid_tally))
    else $error("band tally exceeds valid tally");

  // An empty set has no extremes
  assert property (@(posedge clk) disable iff (rst)
      (valid_tally == '0) |-> ((running_max == '0) && (running_sum == '0)))
    else $error("statistics present with no valid sample");

endmodule

### rtl/tbs_ctrl.sv
// Controller: accepts samples, sequences the division and the summary hand-off.
module tbs_ctrl
  import tbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output tbs_cmd_t    cmd,
  input  tbs_status_t status
);

  typedef enum logic [1:0] {
    S_RUN,
    S_START,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state;
  logic   accept;
  logic   slot_free;

  assign s_tready  = (state == S_RUN);
  assign accept    = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // Commands for the datapath
  always_comb begin
    cmd.take      = accept;
    cmd.div_start = (state == S_START);
    cmd.emit      = (state == S_EMIT) && slot_free;
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      m_tvalid <= 1'b0;
    end else begin
      // Raise the result on an emit, drop it once taken
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_RUN: begin
          if (accept && s_tlast) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (status.div_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state <= S_RUN;
          end
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  // The summary register is loaded only when the previous result is gone
  assert property (@(posedge clk) disable iff (rst) cmd.emit |-> (!m_tvalid || m_tready))
    else $error("summary overwritten before transaction");

  // The divider finishes only while the controller waits for it
  assert property (@(posedge clk) disable iff (rst) status.div_done |-> (state == S_DIV))
    else $error("division completed outside the wait state");

  // A new result appears only right after the emit step
  assert property (@(posedge clk) disable iff (rst)
      $rose(m_tvalid) |-> $past(state == S_EMIT))
    else $error("result raised without an emit");

endmodule
